>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, removed when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/hqsd_pkg.sv
// ----------------------------------------------------------------------------
// hqsd_pkg
// Types, constants and helpers of the hall quadrature speed decoder.
// ----------------------------------------------------------------------------
package hqsd_pkg;

  localparam int TICK_WIDTH_DEF     = 16;
  localparam int POSITION_WIDTH_DEF = 32;

  localparam int POS_OUT_WIDTH   = 32;
  localparam int SPEED_WIDTH     = 24;
  localparam int FRAC_BITS       = 8;
  localparam int SCALE_WIDTH     = 16;
  localparam int TIMEOUT_WIDTH   = 8;
  localparam int PERIOD_WIDTH    = 5;
  localparam int PDIV_WIDTH      = 4;
  localparam int DIV_CNT_WIDTH   = $clog2(SPEED_WIDTH);
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 16;

  localparam logic [PERIOD_WIDTH-1:0]  PERIOD_MIN = 5'd1;
  localparam logic [PERIOD_WIDTH-1:0]  PERIOD_MAX = 5'd16;

  localparam logic [SCALE_WIDTH-1:0]   SCALE_RESET   = 16'd20000;
  localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 8'd100;
  localparam logic [PERIOD_WIDTH-1:0]  PERIOD_RESET  = 5'd5;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPEED_SCALE  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STOP_TIMEOUT = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPEED_PERIOD = 2'd2;

  localparam logic [1:0] LINES_NONE = 2'b00;
  localparam logic [1:0] LINE1      = 2'b01;
  localparam logic [1:0] LINE2      = 2'b10;
  localparam logic [1:0] LINES_BOTH = 2'b11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  function automatic logic [1:0] slot_of(input logic [1:0] lines);
    logic [1:0] slot;
    case (lines)
      LINE1:      slot = 2'd0;
      LINES_BOTH: slot = 2'd1;
      LINE2:      slot = 2'd2;
      default:    slot = 2'd3;
    endcase
    return slot;
  endfunction

endpackage

>>> hw/rtl/hall_quadrature_speed_decoder_unit.sv
// Result: valid in the cycle after an accepted item when no speed division runs, else after
// ST_DIV (bit-serial restoring divider, one quotient bit per cycle). No new item is taken
// until the previous result is accepted, so an output stall also holds the input.
// Reset: synchronous rst restores register defaults and clears all state but divider num/rem.
// ----------------------------------------------------------------------------
// hall_quadrature_speed_decoder_unit
// Debounced hall quadrature decoder with pulse-period speed estimate.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hall_quadrature_speed_decoder_unit
  import hqsd_pkg::*;
#(
  parameter int TICK_WIDTH     = TICK_WIDTH_DEF,
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              hall1_level,
  input  logic                              hall2_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [POS_OUT_WIDTH-1:0]   position,
  output logic [SPEED_WIDTH-1:0]            speed_q8,
  output logic                              step_valid,
  output logic                              step_up
);

  logic [SCALE_WIDTH-1:0]    speed_scale;
  logic [TIMEOUT_WIDTH-1:0]  stop_timeout;
  logic [PERIOD_WIDTH-1:0]   speed_period;

  state_t state, state_next;

  logic [1:0]                sampled_lines, sampled_lines_next;
  logic [1:0]                stable_lines, stable_lines_next;
  logic [1:0]                prev_lines, prev_lines_next;
  logic [POSITION_WIDTH-1:0] step_count, step_count_next;
  logic [TICK_WIDTH-1:0]     tick_counter, tick_counter_next;
  logic [TICK_WIDTH-1:0]     edge_ts [4];
  logic [TICK_WIDTH-1:0]     pulse_width, pulse_width_next;
  logic [TIMEOUT_WIDTH-1:0]  idle_periods, idle_periods_next;
  logic [PDIV_WIDTH-1:0]     period_divider, period_divider_next;
  logic [SPEED_WIDTH-1:0]    current_speed, current_speed_next;

  logic [1:0]                now_lines;
  logic [1:0]                change;
  logic [1:0]                slot;
  logic                      valid_next;
  logic                      up_next;
  logic [PERIOD_WIDTH-1:0]   period_eff;
  logic [PERIOD_WIDTH-1:0]   pdiv_inc;
  logic                      update_now;
  logic                      div_start;

  logic [TICK_WIDTH-1:0]     rem, rem_next;
  logic [TICK_WIDTH:0]       rem_shift;
  logic [TICK_WIDTH:0]       rem_sub;
  logic                      qbit;
  logic [SPEED_WIDTH-1:0]    num, num_next;
  logic [DIV_CNT_WIDTH-1:0]  div_count;

  logic                      in_accept;
  logic                      out_accept;

  assign cfg_ready  = 1'b1;
  assign in_stall   = (state != ST_IDLE);
  assign out_valid  = (state == ST_DONE);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign speed_q8   = current_speed;

  generate
    if (POSITION_WIDTH >= POS_OUT_WIDTH) begin : g_pos_trunc
      assign position = $signed(step_count[POS_OUT_WIDTH-1:0]);
    end else begin : g_pos_ext
      assign position = $signed({{(POS_OUT_WIDTH - POSITION_WIDTH){1'b0}}, step_count});
    end
  endgenerate

  // tick update
  always_comb begin
    now_lines           = {~hall2_level, ~hall1_level};
    tick_counter_next   = tick_counter + 1'b1;
    sampled_lines_next  = sampled_lines;
    stable_lines_next   = stable_lines;
    prev_lines_next     = prev_lines;
    step_count_next     = step_count;
    pulse_width_next    = pulse_width;
    valid_next          = 1'b0;
    up_next             = 1'b0;
    change              = now_lines ^ prev_lines;
    slot                = slot_of(now_lines);
    if (now_lines == sampled_lines) begin
      stable_lines_next = now_lines;
      if (change != LINES_NONE) begin
        prev_lines_next = now_lines;
        if (change == LINE1) begin
          valid_next = 1'b1;
          up_next    = (now_lines == LINES_NONE) || (now_lines == LINES_BOTH);
        end else if (change == LINE2) begin
          valid_next = 1'b1;
          up_next    = (now_lines == LINE1) || (now_lines == LINE2);
        end
        if (valid_next) begin
          step_count_next  = up_next ? step_count + 1'b1 : step_count - 1'b1;
          pulse_width_next = tick_counter_next - edge_ts[slot];
        end
      end
    end else begin
      sampled_lines_next = now_lines;
    end

    if (speed_period < PERIOD_MIN) begin
      period_eff = PERIOD_MIN;
    end else if (speed_period > PERIOD_MAX) begin
      period_eff = PERIOD_MAX;
    end else begin
      period_eff = speed_period;
    end
    pdiv_inc = {1'b0, period_divider} + 1'b1;
    if (pdiv_inc < period_eff) begin
      update_now          = 1'b0;
      period_divider_next = pdiv_inc[PDIV_WIDTH-1:0];
    end else begin
      update_now          = 1'b1;
      period_divider_next = '0;
    end

    div_start          = update_now && (pulse_width_next != '0);
    idle_periods_next  = idle_periods;
    current_speed_next = current_speed;
    if (update_now && (pulse_width_next == '0)) begin
      if (idle_periods < stop_timeout) begin
        idle_periods_next = idle_periods + 1'b1;
      end else begin
        current_speed_next = '0;
      end
    end
  end

  // divider step
  always_comb begin
    rem_shift = {rem, num[SPEED_WIDTH-1]};
    rem_sub   = rem_shift - {1'b0, pulse_width};
    qbit      = (rem_shift >= {1'b0, pulse_width});
    rem_next  = qbit ? rem_sub[TICK_WIDTH-1:0] : rem_shift[TICK_WIDTH-1:0];
    num_next  = {num[SPEED_WIDTH-2:0], qbit};
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = div_start ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_count == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_accept) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_scale    <= SCALE_RESET;
      stop_timeout   <= TIMEOUT_RESET;
      speed_period   <= PERIOD_RESET;
      sampled_lines  <= LINES_NONE;
      stable_lines   <= LINES_NONE;
      prev_lines     <= LINES_NONE;
      step_count     <= '0;
      tick_counter   <= '0;
      for (int i = 0; i < 4; i++) begin
        edge_ts[i] <= '0;
      end
      pulse_width    <= '0;
      idle_periods   <= '0;
      period_divider <= '0;
      current_speed  <= '0;
      step_valid     <= 1'b0;
      step_up        <= 1'b0;
      div_count      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SPEED_SCALE:  speed_scale  <= cfg_data[SCALE_WIDTH-1:0];
          CFG_STOP_TIMEOUT: stop_timeout <= cfg_data[TIMEOUT_WIDTH-1:0];
          CFG_SPEED_PERIOD: speed_period <= cfg_data[PERIOD_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        sampled_lines  <= sampled_lines_next;
        stable_lines   <= stable_lines_next;
        prev_lines     <= prev_lines_next;
        step_count     <= step_count_next;
        tick_counter   <= tick_counter_next;
        pulse_width    <= pulse_width_next;
        idle_periods   <= idle_periods_next;
        period_divider <= period_divider_next;
        current_speed  <= current_speed_next;
        step_valid     <= valid_next;
        step_up        <= valid_next && up_next;
        if (valid_next) begin
          edge_ts[slot] <= tick_counter_next;
        end
        div_count <= DIV_CNT_WIDTH'(SPEED_WIDTH - 1);
      end else if (state == ST_DIV) begin
        div_count <= div_count - 1'b1;
        if (div_count == '0) begin
          current_speed <= num_next;
          pulse_width   <= '0;
          idle_periods  <= '0;
        end
      end
    end
  end

  // divider datapath, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      num <= {speed_scale, {FRAC_BITS{1'b0}}};
      rem <= '0;
    end else if (state == ST_DIV) begin
      num <= num_next;
      rem <= rem_next;
    end
  end

  `ASSERT_IMPLY(a_div_nonzero, clk, rst, state == ST_DIV, pulse_width != '0)
  `ASSERT_IMPLY(a_up_has_step, clk, rst, out_valid && step_up, step_valid)
  `ASSERT_ALWAYS(a_pdiv_range, clk, rst, {1'b0, period_divider} < PERIOD_MAX)
  `ASSERT_NEXT(a_div_done, clk, rst, state == ST_DIV && div_count == '0, out_valid)

endmodule
